FILE: rtl/pcc_pkg.sv
// Package for the path containment checker: default sizes, character codes,
// register indexes and the ASCII case fold. Depends on nothing.
package pcc_pkg;

  localparam int NameLenDef = 32;
  localparam int DepthDef   = 24;
  localparam int PathLenDef = 256;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;

  localparam logic RegCageActive = 1'b0;
  localparam logic RegFileAccess = 1'b1;

  // Only 'A' through 'Z' fold to lower case.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CharUpA && c <= CharUpZ) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

FILE: rtl/pcc_if.sv
// Valid/ready channel interfaces for the path containment checker.
// Depends on nothing.
interface pcc_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] character;
  modport source(output valid, action, character, input ready);
  modport sink(input valid, action, character, output ready);
endinterface

interface pcc_out_if;
  logic valid;
  logic ready;
  logic allowed;
  modport source(output valid, allowed, input ready);
  modport sink(input valid, allowed, output ready);
endinterface

FILE: rtl/path_containment_checker.sv
// Path containment checker top level.
// Depends on pcc_pkg and the channel interfaces in pcc_if.sv.

// The block takes one byte per item, either a byte of the root path
// (action 0) or of the checked path (action 1); a zero byte ends a string.
// Both strings are normalized on the fly: slash runs collapse, "." is
// dropped, ".." pops one component, names are cut at NAME_LEN bytes and
// components past DEPTH are dropped; the normalized text is limited to
// PATH_LEN-1 bytes. Root bytes go into an internal memory. Each checked
// path byte is compared, case-insensitively, against the root byte at the
// same component and offset, and a match mark is kept for each path
// component, so the verdict at the end of a path is a parallel check over
// the marks. A new item is accepted every cycle unless the input is
// stalled; an item passes the input register, then the stage B register
// with the root memory read, then the result register, which holds the
// verdict of a terminating zero byte. A spare result register catches a
// verdict that arrives while the previous one is still waiting, so the
// input is stalled only while that spare register is full, and the input
// ready never depends combinationally on the output ready.
// There is no clearing pass after reset.
module path_containment_checker
  import pcc_pkg::*;
#(
  parameter int NAME_LEN = NameLenDef,
  parameter int DEPTH    = DepthDef,
  parameter int PATH_LEN = PathLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcc_in_if.sink      in_ch,
  pcc_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NW  = $clog2(NAME_LEN + 1);
  localparam int DCW = $clog2(DEPTH + 1);
  localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int MD  = DEPTH * NAME_LEN;
  localparam int AW  = (MD > 1) ? $clog2(MD) : 1;
  localparam int LIM = PATH_LEN - 1;
  localparam int OW  = $clog2(PATH_LEN);
  localparam int SW  = OW + NW + 1;

  // Configuration registers.
  logic cage_q, fa_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cage_q <= 1'b0;
      fa_q   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegCageActive) begin
        cage_q <= pwdata[0];
      end else begin
        fa_q <= pwdata[0];
      end
    end
  end
  assign pready = 1'b1;
  assign prdata = {31'd0, (paddr[2] == RegFileAccess) ? fa_q : cage_q};

  // Pipeline enable: hold everything only while the spare result register
  // is occupied.
  logic en;
  logic s2_v_q, s2_end_q;
  logic out_v_q, out_a_q;
  logic skid_v_q, skid_a_q;
  assign en          = !skid_v_q;
  assign in_ch.ready = en;

  // Input register.
  logic       s1_v_q, s1_act_q;
  logic [7:0] s1_ch_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_ch.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en && in_ch.valid) begin
      s1_act_q <= in_ch.action;
      s1_ch_q  <= in_ch.character;
    end
  end

  // Parsing state.
  logic            in_str_q, kind_q;
  logic [DCW-1:0]  rdep_q, pdep_q;
  logic [NW-1:0]   nlen_q;
  logic [7:0]      first_q, second_q;
  logic [OW-1:0]   roff_q;

  // Root component stack: length, start offset in the text, whether the
  // start lies inside the text limit, compared length and prefix-only flag.
  logic [NW-1:0] ra_q [DEPTH];
  logic [NW-1:0] rc_q [DEPTH];
  logic [OW-1:0] rs_q [DEPTH];
  logic [DEPTH-1:0] rw_q, rp_q;

  logic [7:0] root_mem [MD];

  // Stage A decode.
  logic           start, is_sep;
  logic [NW-1:0]  nlen_e;
  logic [7:0]     first_e, second_e;
  logic [DCW-1:0] dep_e, dep_n;
  logic [OW-1:0]  roff_e;
  logic           push, pop, store_ok, room_ok;
  logic [IW-1:0]  slot;
  logic [SW-1:0]  sum, room;
  logic [AW-1:0]  addr;

  always_comb begin
    start    = !in_str_q || (s1_act_q != kind_q);
    is_sep   = (s1_ch_q == CharNul) || (s1_ch_q == CharSlash);
    nlen_e   = start ? '0 : nlen_q;
    first_e  = start ? '0 : first_q;
    second_e = start ? '0 : second_q;
    dep_e    = start ? '0 : (s1_act_q ? pdep_q : rdep_q);
    roff_e   = (start && !s1_act_q) ? '0 : roff_q;
    slot     = dep_e[IW-1:0];
    store_ok = dep_e < DCW'(DEPTH);
    room_ok  = nlen_e < NW'(NAME_LEN);
    push     = 1'b0;
    pop      = 1'b0;
    if (is_sep && nlen_e != '0) begin
      if (nlen_e == NW'(1) && first_e == CharDot) begin
        push = 1'b0;
      end else if (nlen_e == NW'(2) && first_e == CharDot && second_e == CharDot) begin
        pop = dep_e != '0;
      end else begin
        push = store_ok;
      end
    end
    dep_n = dep_e;
    if (push) begin
      dep_n = dep_e + DCW'(1);
    end else if (pop) begin
      dep_n = dep_e - DCW'(1);
    end
    sum  = SW'(roff_e) + SW'(1) + SW'(nlen_e);
    room = SW'(LIM) - SW'(1) - SW'(roff_e);
    addr = AW'(int'(slot) * NAME_LEN + int'(nlen_e));
  end

  logic a_go;
  assign a_go = en && s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_str_q <= 1'b0;
      kind_q   <= 1'b0;
      rdep_q   <= '0;
      pdep_q   <= '0;
      nlen_q   <= '0;
      first_q  <= '0;
      second_q <= '0;
      roff_q   <= '0;
    end else if (a_go) begin
      kind_q <= s1_act_q;
      if (s1_act_q) begin
        pdep_q <= dep_n;
      end else begin
        rdep_q <= dep_n;
      end
      if (is_sep) begin
        in_str_q <= s1_ch_q != CharNul;
        nlen_q   <= '0;
        first_q  <= '0;
        second_q <= '0;
        if (!s1_act_q) begin
          if (push) begin
            roff_q <= (sum >= SW'(LIM)) ? OW'(LIM) : sum[OW-1:0];
          end else if (pop) begin
            roff_q <= rs_q[slot - IW'(1)];
          end else begin
            roff_q <= roff_e;
          end
        end
      end else begin
        in_str_q <= 1'b1;
        if (!s1_act_q) begin
          roff_q <= roff_e;
        end
        if (room_ok) begin
          nlen_q   <= nlen_e + NW'(1);
          first_q  <= (nlen_e == '0) ? s1_ch_q : first_e;
          second_q <= (nlen_e == NW'(1)) ? s1_ch_q : second_e;
        end else begin
          nlen_q   <= nlen_e;
          first_q  <= first_e;
          second_q <= second_e;
        end
      end
    end
  end

  // Root component bookkeeping, written when a root name is kept.
  always_ff @(posedge clk_i) begin
    if (a_go && !s1_act_q && push) begin
      ra_q[slot] <= nlen_e;
      rs_q[slot] <= roff_e;
      rw_q[slot] <= roff_e < OW'(LIM);
      rp_q[slot] <= sum >= SW'(LIM);
      rc_q[slot] <= (SW'(nlen_e) > room) ? room[NW-1:0] : nlen_e;
    end
  end

  // Root byte memory: one write and one registered read per cycle, held while stalled.
  logic [7:0] rdata_q;
  always_ff @(posedge clk_i) begin
    if (a_go && !s1_act_q && !is_sep && room_ok && store_ok) begin
      root_mem[addr] <= s1_ch_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      rdata_q <= root_mem[addr];
    end
  end

  // Stage B register: what the path item asks of the match logic.
  logic           s2_chr_q, s2_push_q;
  logic [IW-1:0]  s2_slot_q;
  logic [NW-1:0]  s2_k_q;
  logic [DCW-1:0] s2_dep_q;
  logic [7:0]     s2_ch_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q    <= 1'b0;
      s2_end_q  <= 1'b0;
      s2_chr_q  <= 1'b0;
      s2_push_q <= 1'b0;
    end else if (en) begin
      s2_v_q    <= a_go && s1_act_q;
      s2_end_q  <= s1_ch_q == CharNul;
      s2_chr_q  <= !is_sep && room_ok && store_ok;
      s2_push_q <= push;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_slot_q <= slot;
      s2_k_q    <= nlen_e;
      s2_dep_q  <= dep_n;
      s2_ch_q   <= s1_ch_q;
    end
  end

  // Match logic: a running match for the current path name, and one mark
  // per kept path component.
  logic             cur_q;
  logic [DEPTH-1:0] mark_q, mark_d;
  logic             chr_ok, len_ok, verdict;

  always_comb begin
    chr_ok = (s2_k_q >= rc_q[s2_slot_q]) ||
             (fold_case(rdata_q) == fold_case(s2_ch_q));
    len_ok = rp_q[s2_slot_q] ? (s2_k_q >= rc_q[s2_slot_q]) :
                               (s2_k_q == ra_q[s2_slot_q]);
    mark_d = mark_q;
    if (s2_v_q && s2_push_q) begin
      mark_d[s2_slot_q] = cur_q && len_ok;
    end
    verdict = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      if (DCW'(i) < rdep_q && rw_q[i] && !(DCW'(i) < s2_dep_q && mark_d[i])) begin
        verdict = 1'b0;
      end
    end
    if (!cage_q) begin
      verdict = 1'b1;
    end else if (!fa_q) begin
      verdict = 1'b0;
    end else if (rdep_q == '0 || LIM == 1) begin
      verdict = 1'b1;
    end
  end

  // Running name match: restarts at a name's first byte and follows each stored path name byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= 1'b1;
    end else if (en && s2_v_q && s2_chr_q) begin
      cur_q <= ((s2_k_q == '0) || cur_q) && chr_ok;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mark_q <= mark_d;
    end
  end

  // Result register and its spare: a verdict that arrives while the result
  // register is still waiting goes to the spare, and moves up when the
  // waiting one is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      out_a_q  <= 1'b0;
      skid_v_q <= 1'b0;
      skid_a_q <= 1'b0;
    end else begin
      if (en && s2_v_q && s2_end_q) begin
        if (!out_v_q || out_ch.ready) begin
          out_v_q <= 1'b1;
          out_a_q <= verdict;
        end else begin
          skid_v_q <= 1'b1;
          skid_a_q <= verdict;
        end
      end else if (out_ch.ready) begin
        out_v_q  <= skid_v_q;
        if (skid_v_q) begin
          out_a_q <= skid_a_q;
        end
        skid_v_q <= 1'b0;
      end
    end
  end
  assign out_ch.valid   = out_v_q;
  assign out_ch.allowed = out_a_q;

endmodule

FILE: dv/tb_path_containment_checker.sv
// Self-checking testbench for path_containment_checker: streams root and path strings and
// checks each random verdict against a behavioral predictor, each directed one against a set value.
// Depends on pcc_pkg, the channel interfaces in pcc_if.sv and the RTL.
`timescale 1ns / 1ps

module tb_path_containment_checker;
  import pcc_pkg::*;

  localparam int NameLen  = NameLenDef;
  localparam int Depth    = DepthDef;
  localparam int PathLen  = PathLenDef;
  localparam int IdleLimit = 3000;
  localparam int DrainWait = 8;
  localparam logic [2:0] AddrCage = {RegCageActive, 2'b00};
  localparam logic [2:0] AddrFile = {RegFileAccess, 2'b00};
  localparam bit KindRoot = 1'b0;
  localparam bit KindPath = 1'b1;

  typedef struct packed {
    bit       act;
    bit [7:0] ch;
    bit       typed;
    bit       want;
  } item_t;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  pcc_in_if  in_ch();
  pcc_out_if out_ch();

  path_containment_checker uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Stimulus waiting to be sent, and verdicts waiting to come out.
  item_t pending_items[$];
  bit    verdicts_due[$];
  int    errors;
  int    idle_cycles;
  int    hold_left;
  int    items_sent;

  // Shadow copy of the block: registers, both stacks of names and the
  // state of the name being collected.
  bit       cage_q, facc_q;
  bit [7:0] names[2][Depth][NameLen];
  int       name_len[2][Depth];
  int       depth_q[2];
  int       cur_len;
  bit [7:0] first_ch, second_ch;
  bit       busy;
  bit       busy_kind;

  // Root components of the last root, reused to build likely-matching paths.
  string root_words[$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report(input string what, input bit got, input bit want);
    $display("MISMATCH %s: allowed got %0d, want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void clear_name();
    cur_len = 0;
    first_ch = 8'h00;
    second_ch = 8'h00;
  endfunction

  // Closes the name being collected: empty names and "." are dropped, ".." pops,
  // anything else is pushed unless the stack is full.
  function automatic void close_name(input int k);
    if (cur_len == 1 && first_ch == CharDot) begin
    end else if (cur_len == 2 && first_ch == CharDot && second_ch == CharDot) begin
      if (depth_q[k] > 0) depth_q[k]--;
    end else if (cur_len > 0 && depth_q[k] < Depth) begin
      name_len[k][depth_q[k]] = cur_len;
      depth_q[k]++;
    end
    clear_name();
  endfunction

  function automatic void flatten(input int k, ref bit [7:0] t[$]);
    t.delete();
    for (int i = 0; i < depth_q[k]; i++) begin
      if (t.size() < PathLen - 1) t.push_back(CharSlash);
      for (int j = 0; j < name_len[k][i]; j++) begin
        if (t.size() < PathLen - 1) t.push_back(names[k][i][j]);
      end
    end
    if (t.size() == 0) t.push_back(CharSlash);
  endfunction

  function automatic bit [7:0] fold_byte(input bit [7:0] c);
    return (c >= CharUpA && c <= CharUpZ) ? c + 8'd32 : c;
  endfunction

  function automatic bit containment_verdict();
    bit [7:0] rt[$];
    bit [7:0] pt[$];
    if (!cage_q) return 1'b1;
    if (!facc_q) return 1'b0;
    flatten(KindRoot, rt);
    if (rt.size() == 1) return 1'b1;
    flatten(KindPath, pt);
    if (pt.size() < rt.size()) return 1'b0;
    for (int i = 0; i < rt.size(); i++) begin
      if (fold_byte(rt[i]) != fold_byte(pt[i])) return 1'b0;
    end
    return (pt.size() == rt.size() || pt[rt.size()] == CharSlash);
  endfunction

  // Advances the shadow state by one accepted item and queues the verdict at the end of a path string.
  function automatic void track_item(input item_t it);
    int k;
    k = it.act;
    // A byte of the other kind abandons the unfinished string.
    if (busy && it.act != busy_kind) busy = 1'b0;
    if (!busy) begin
      busy = 1'b1;
      busy_kind = it.act;
      depth_q[k] = 0;
      clear_name();
    end
    if (it.ch == CharNul || it.ch == CharSlash) begin
      close_name(k);
      if (it.ch == CharNul) begin
        busy = 1'b0;
        if (it.act == KindPath) verdicts_due.push_back(it.typed ? it.want : containment_verdict());
      end
    end else if (cur_len < NameLen) begin
      if (depth_q[k] < Depth) names[k][depth_q[k]][cur_len] = it.ch;
      if (cur_len == 0) first_ch = it.ch;
      else if (cur_len == 1) second_ch = it.ch;
      cur_len++;
    end
  endfunction

  task automatic apb_write(input logic [2:0] addr, input bit val);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = {31'd0, val};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == AddrCage) cage_q = val;
    else facc_q = val;
  endtask

  // Queues the bytes of one string; the zero terminator is left off when a
  // string is to be abandoned.
  task automatic add_string(input bit k, input string s, input bit term,
                            input bit typed, input bit want);
    item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it = '{act: k, ch: s[i], typed: 1'b0, want: 1'b0};
      pending_items.push_back(it);
    end
    if (term) begin
      it = '{act: k, ch: CharNul, typed: typed, want: want};
      pending_items.push_back(it);
    end
  endtask

  function automatic string random_word();
    string s;
    s = "";
    case ($urandom_range(0, 11))
      0: s = ".";
      1: s = "..";
      2: s = "a";
      3: s = "B";
      4: s = "usr";
      5: s = "Lib";
      6: s = "...";
      7: s = "";
      8: begin
        // Name near or past NameLen bytes: only the first NameLen bytes count.
        repeat (NameLen - 2 + $urandom_range(0, 10)) s = {s, "x"};
        s = {s, $urandom_range(0, 1) ? "Q" : "q"};
      end
      default: begin
        repeat ($urandom_range(1, 3)) begin
          byte unsigned c;
          c = $urandom_range(1, 255);
          if (c == CharSlash) c = "Z";
          s = {s, string'(c)};
        end
      end
    endcase
    return s;
  endfunction

  function automatic string flip_case(input string w);
    string s;
    s = w;
    for (int i = 0; i < s.len(); i++) begin
      if ($urandom_range(0, 3) == 0) begin
        if (s[i] >= "a" && s[i] <= "z") s[i] = s[i] - 32;
        else if (s[i] >= "A" && s[i] <= "Z") s[i] = s[i] + 32;
      end
    end
    return s;
  endfunction

  function automatic string join_words(input string w[$]);
    string s;
    s = "";
    if ($urandom_range(0, 4) != 0) s = "/";
    foreach (w[i]) begin
      s = {s, w[i], "/"};
      if ($urandom_range(0, 7) == 0) s = {s, "/"};
    end
    if (s.len() > 0 && $urandom_range(0, 1)) s = s.substr(0, s.len() - 2);
    return s;
  endfunction

  // Builds one random string: mostly paths derived from the current root,
  // some fresh roots, some unrelated paths and a few abandoned strings.
  task automatic add_random_string();
    string w[$];
    int n;
    bit term;
    term = ($urandom_range(0, 19) != 0);
    if ($urandom_range(0, 4) == 0) begin
      n = ($urandom_range(0, 15) == 0) ? Depth + $urandom_range(0, 3) : $urandom_range(0, 4);
      repeat (n) w.push_back(random_word());
      root_words = w;
      add_string(KindRoot, join_words(w), term, 1'b0, 1'b0);
    end else begin
      if ($urandom_range(0, 9) < 7) begin
        foreach (root_words[i]) w.push_back(flip_case(root_words[i]));
        if (w.size() > 0 && $urandom_range(0, 5) == 0) void'(w.pop_back());
        if (w.size() > 0 && $urandom_range(0, 7) == 0) w[w.size()-1] = {w[w.size()-1], "e"};
        repeat ($urandom_range(0, 3)) w.push_back(random_word());
      end else begin
        repeat ($urandom_range(0, 5)) w.push_back(random_word());
      end
      add_string(KindPath, join_words(w), term, 1'b0, 1'b0);
    end
  endtask

  // Sends everything queued, in bursts of random length with random gaps.
  task automatic send_all();
    int burst;
    while (pending_items.size() > 0) begin
      burst = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
      while (burst > 0 && pending_items.size() > 0) begin
        item_t it;
        it = pending_items.pop_front();
        in_ch.valid = 1'b1;
        in_ch.action = it.act;
        in_ch.character = it.ch;
        do @(posedge clk_i); while (!in_ch.ready);
        track_item(it);
        items_sent++;
        burst--;
        @(negedge clk_i);
      end
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    while (verdicts_due.size() > 0) @(negedge clk_i);
    // Root strings end without a verdict, so the pipeline may still be busy.
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic random_phase(input int n_items, input bit pause_mid);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      add_random_string();
      send_all();
      if (pause_mid && items_sent > target - n_items / 2) begin
        drain();
        pause_mid = 1'b0;
      end
    end
  endtask

  // Receiver: ready pattern changes every so often; a long hold-off can be
  // requested to back the block up into its input.
  initial begin
    int mode, left;
    out_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end
      left--;
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        case (mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = $urandom_range(0, 1);
          2: out_ch.ready = ($urandom_range(0, 3) == 0);
          default: out_ch.ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Result checker and idle watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        if (verdicts_due.size() == 0) report("unexpected verdict", out_ch.allowed, 1'b0);
        else begin
          bit want;
          want = verdicts_due.pop_front();
          if (out_ch.allowed !== want) report("verdict", out_ch.allowed, want);
        end
      end
      if (idle_cycles > IdleLimit) begin
        $display("tb_path_containment_checker NOT OK");
        $finish;
      end
    end
  end

  // Directed strings: empty path, dot handling, pops past the top, slash
  // runs, case, high bytes and a switch of kind in mid-string. All run with
  // the reset registers, where the cage is inactive and every path passes.
  bit    dir_kind[] = '{KindPath, KindRoot, KindPath, KindRoot, KindPath, KindPath};
  string dir_text[] = '{"", "/A/./../..", "//x/./y/", "/q", "/a/..", "\377\200/b"};
  bit    dir_term[] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

  initial begin
    errors = 0; idle_cycles = 0; hold_left = 0; items_sent = 0;
    cage_q = 1'b0; facc_q = 1'b0;
    foreach (depth_q[k]) depth_q[k] = 0;
    clear_name();
    busy = 1'b0; busy_kind = 1'b0;
    in_ch.valid = 1'b0; in_ch.action = 1'b0; in_ch.character = 8'h00;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    rst_ni = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_text[i]) add_string(dir_kind[i], dir_text[i], dir_term[i], 1'b1, 1'b1);
    send_all();
    drain();

    apb_write(AddrCage, 1'b1);
    apb_write(AddrFile, 1'b1);
    random_phase(700, 1'b1);
    drain();
    apb_write(AddrFile, 1'b0);
    random_phase(200, 1'b0);
    drain();
    apb_write(AddrCage, 1'b0);
    apb_write(AddrFile, 1'b1);
    random_phase(200, 1'b0);
    drain();
    apb_write(AddrCage, 1'b1);
    // Hold the receiver off while the sender keeps going.
    hold_left = 400;
    random_phase(900, 1'b0);
    drain();

    if (errors == 0) $display("tb_path_containment_checker OK");
    else $display("tb_path_containment_checker NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
rtl/pcc_pkg.sv
rtl/pcc_if.sv
rtl/path_containment_checker.sv
dv/tb_path_containment_checker.sv
